// ----- hw/rtl/rpls_pkg.sv -----
// Shared types, register indexes and helpers for the release pulse lockout sequencer.
`default_nettype none

package rpls_pkg;

  localparam int DUR_W   = 12;
  localparam int BLINK_W = 4;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 3;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_STARTUP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_POLL       = 3'd1;
  localparam logic [IDX_W-1:0] REG_PULSE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_FAST_HALF  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FAST_COUNT = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLOW_HALF  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SLOW_COUNT = 3'd6;

  typedef struct packed {
    logic [DUR_W-1:0]   startup_ticks;
    logic [DUR_W-1:0]   poll_ticks;
    logic [DUR_W-1:0]   pulse_ticks;
    logic [DUR_W-1:0]   fast_half_ticks;
    logic [BLINK_W-1:0] fast_blinks;
    logic [DUR_W-1:0]   slow_half_ticks;
    logic [BLINK_W-1:0] slow_blinks;
  } cfg_t;

  typedef struct packed {
    logic led_two;
    logic led_one;
    logic line_level;
  } levels_t;

  // Zero durations count as one tick
  function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
    at_least_one = (v == '0) ? DUR_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rpls_cfg.sv -----
// Configuration register file of the release pulse lockout sequencer.
`default_nettype none

module rpls_cfg
  import rpls_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] index,
  input  wire logic [CFG_W-1:0] wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.startup_ticks   <= 12'd500;
      cfg.poll_ticks      <= 12'd10;
      cfg.pulse_ticks     <= 12'd10;
      cfg.fast_half_ticks <= 12'd30;
      cfg.fast_blinks     <= 4'd6;
      cfg.slow_half_ticks <= 12'd100;
      cfg.slow_blinks     <= 4'd4;
    end else if (we) begin
      unique case (index)
        REG_STARTUP:    cfg.startup_ticks   <= wdata;
        REG_POLL:       cfg.poll_ticks      <= wdata;
        REG_PULSE:      cfg.pulse_ticks     <= wdata;
        REG_FAST_HALF:  cfg.fast_half_ticks <= wdata;
        REG_FAST_COUNT: cfg.fast_blinks     <= wdata[BLINK_W-1:0];
        REG_SLOW_HALF:  cfg.slow_half_ticks <= wdata;
        REG_SLOW_COUNT: cfg.slow_blinks     <= wdata[BLINK_W-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rpls_core.sv -----
// Phase sequencer: counters, flags and LED/line levels, one step per accepted tick.
`default_nettype none

module rpls_core
  import rpls_pkg::*;
#(
  parameter int COUNT_WIDTH = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic button_level,
  input  wire logic port_two_selected,
  input  wire cfg_t cfg,
  output levels_t   levels_next
);

  localparam int LW = (COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_IDLE     = 3'd1,
    PH_PULSE    = 3'd2,
    PH_FAST_ON  = 3'd3,
    PH_FAST_OFF = 3'd4,
    PH_SLOW_OFF = 3'd5,
    PH_SLOW_ON  = 3'd6
  } phase_t;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [BLINK_W-1:0]     blink_count, blink_count_next;
  logic                   armed, armed_next;
  levels_t                levels;

  logic [DUR_W-1:0]   seg_len;
  logic               seg_done;
  logic               no_sample;
  logic [BLINK_W-1:0] blink_inc;

  always_comb begin
    unique case (phase)
      PH_START:                seg_len = cfg.startup_ticks;
      PH_PULSE:                seg_len = at_least_one(cfg.pulse_ticks);
      PH_FAST_ON, PH_FAST_OFF: seg_len = at_least_one(cfg.fast_half_ticks);
      default:                 seg_len = at_least_one(cfg.slow_half_ticks);
    endcase
  end

  assign seg_done  = (phase != PH_IDLE) && (LW'(tick_count) >= LW'(seg_len));
  assign blink_inc = blink_count + BLINK_W'(1);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    blink_count_next = blink_count;
    armed_next       = armed;
    levels_next      = levels;
    no_sample        = 1'b0;

    // End of the current timed segment; the next one starts in this same tick
    if (seg_done) begin
      tick_count_next = '0;
      unique case (phase)
        PH_START: begin
          levels_next.led_one = 1'b0;
          levels_next.led_two = 1'b0;
          phase_next          = PH_IDLE;
        end
        PH_PULSE: begin
          levels_next.line_level = 1'b1;
          if (cfg.fast_blinks != '0) begin
            blink_count_next    = '0;
            levels_next.led_one = 1'b1;
            levels_next.led_two = 1'b1;
            phase_next          = PH_FAST_ON;
          end else if (cfg.slow_blinks != '0) begin
            blink_count_next    = '0;
            levels_next.led_one = 1'b0;
            levels_next.led_two = 1'b0;
            phase_next          = PH_SLOW_OFF;
          end else begin
            levels_next.led_one = !port_two_selected;
            levels_next.led_two = port_two_selected;
            armed_next          = 1'b0;
            phase_next          = PH_IDLE;
            no_sample           = 1'b1;
          end
        end
        PH_FAST_ON: begin
          levels_next.led_one = 1'b0;
          levels_next.led_two = 1'b0;
          phase_next          = PH_FAST_OFF;
        end
        PH_FAST_OFF: begin
          blink_count_next = blink_inc;
          if (blink_inc >= cfg.fast_blinks || blink_inc == '0) begin
            if (cfg.slow_blinks != '0) begin
              blink_count_next    = '0;
              levels_next.led_one = 1'b0;
              levels_next.led_two = 1'b0;
              phase_next          = PH_SLOW_OFF;
            end else begin
              levels_next.led_one = !port_two_selected;
              levels_next.led_two = port_two_selected;
              armed_next          = 1'b0;
              phase_next          = PH_IDLE;
              no_sample           = 1'b1;
            end
          end else begin
            levels_next.led_one = 1'b1;
            levels_next.led_two = 1'b1;
            phase_next          = PH_FAST_ON;
          end
        end
        PH_SLOW_OFF: begin
          levels_next.led_one = !port_two_selected;
          levels_next.led_two = port_two_selected;
          phase_next          = PH_SLOW_ON;
        end
        default: begin
          // slow port-following half
          blink_count_next = blink_inc;
          if (blink_inc >= cfg.slow_blinks || blink_inc == '0) begin
            levels_next.led_one = !port_two_selected;
            levels_next.led_two = port_two_selected;
            armed_next          = 1'b0;
            phase_next          = PH_IDLE;
            no_sample           = 1'b1;
          end else begin
            levels_next.led_one = 1'b0;
            levels_next.led_two = 1'b0;
            phase_next          = PH_SLOW_OFF;
          end
        end
      endcase
    end

    // Idle sample on the first tick of a poll period
    if (phase_next == PH_IDLE && tick_count_next == '0 && !no_sample) begin
      if (button_level) begin
        armed_next          = 1'b1;
        levels_next.led_one = !port_two_selected;
        levels_next.led_two = port_two_selected;
      end else if (armed_next) begin
        levels_next.line_level = 1'b0;
        phase_next             = PH_PULSE;
      end else begin
        levels_next.led_one = !port_two_selected;
        levels_next.led_two = port_two_selected;
      end
    end

    // Advance the tick counter, saturating; wrap the poll period in idle
    if (tick_count_next != COUNT_MAX) begin
      tick_count_next = tick_count_next + COUNT_WIDTH'(1);
    end
    if (phase_next == PH_IDLE &&
        LW'(tick_count_next) >= LW'(at_least_one(cfg.poll_ticks))) begin
      tick_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      tick_count  <= '0;
      blink_count <= '0;
      armed       <= 1'b0;
      levels      <= '{led_two: 1'b1, led_one: 1'b1, line_level: 1'b1};
    end else if (step) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      blink_count <= blink_count_next;
      armed       <= armed_next;
      levels      <= levels_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/release_pulse_lockout_sequencer.sv -----
// Top level of the release pulse lockout sequencer: stream ports, config port, output register.
`default_nettype none

// Usage:
//   Feed one item per 1 ms tick on the s_axis channel: the button level and the
//   selected-port level. Each accepted item yields exactly one result item on
//   m_axis with the line level and both LED drives for that tick.
//   After reset the line and both LEDs are high for startup_ticks ticks, then the
//   LEDs follow the selected port and the idle poll loop runs. A release after the
//   button was seen pressed pulses the line low, then runs the fast and slow blink
//   stages (each skipped when its blink count is zero) while the button is ignored.
//   Latency: the result is valid in the cycle after the item is accepted.
//   Throughput: one item per cycle; the whole step is one pass of next-state
//   logic between the sequencer registers and the output register.
//   Stall: while m_axis_tready is low the result holds in the output register;
//   s_axis_tready stays high as long as that register is empty or being drained
//   in the same cycle, so one new item is taken each cycle the output moves.
//   Reset (rst, synchronous, active high) loads the default timing registers,
//   returns to the start-up phase and empties the output register.
//   Configuration: write cfg_we/cfg_index/cfg_wdata only while no item is in flight.

module release_pulse_lockout_sequencer
  import rpls_pkg::*;
#(
  parameter int COUNT_WIDTH = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,  // [0] button_level, [1] port_two_selected
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [7:0]       m_axis_tdata,  // [0] line_level, [1] led_one, [2] led_two
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  levels_t levels_next;
  levels_t out_levels;
  logic    accept;

  // Take a new item whenever the output register is empty or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rpls_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  rpls_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (accept),
    .button_level      (s_axis_tdata[0]),
    .port_two_selected (s_axis_tdata[1]),
    .cfg               (cfg),
    .levels_next       (levels_next)
  );

  // Output register: valid is control, levels are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_levels <= levels_next;
    end
  end

  assign m_axis_tdata = {5'd0, out_levels.led_two, out_levels.led_one, out_levels.line_level};

endmodule

`default_nettype wire
